// File: rtl/rric_pkg.sv
package rric_pkg;

	// Widths of the storage that follows the position and interval sizes
	localparam int POSITION_WIDTH = 31;
	localparam int INTERVAL_WIDTH = 16;

	// Fixed field widths
	localparam int INDEX_W  = 16;
	localparam int OFFSET_W = 31;
	localparam int OUT_RR_W = 16;
	localparam int SR_W     = 13;
	localparam int MS_W     = 10;
	localparam int RS_W     = 11;
	localparam int RB_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MS_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_HIGH  = 3'd4;

	// Reset values of the registers
	localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 13'd250;
	localparam logic [MS_W-1:0] MS_SCALE_RST    = 10'd1000;
	localparam logic [RS_W-1:0] RATIO_SCALE_RST = 11'd100;
	localparam logic [RB_W-1:0] RATIO_LOW_RST   = 16'd50;
	localparam logic [RB_W-1:0] RATIO_HIGH_RST  = 16'd200;

	// Shared multiplier: position difference or interval by a scale factor
	localparam int MA_W  = (POSITION_WIDTH > INTERVAL_WIDTH) ? POSITION_WIDTH : INTERVAL_WIDTH;
	localparam int MB_W  = (MS_W > RS_W) ? MS_W : RS_W;
	localparam int DVD_W = MA_W + MB_W;

	// Shared divider: quotient and divisor widths
	localparam int Q_W   = (INTERVAL_WIDTH > RB_W) ? INTERVAL_WIDTH : RB_W;
	localparam int DVS_W = (INTERVAL_WIDTH > SR_W) ? INTERVAL_WIDTH : SR_W;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic sel_ratio;
		logic div_start;
		logic rr_take;
		logic ratio_take;
		logic commit_skip;
		logic commit_rr;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic skip;
		logic last;
		logic check;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/rric_div.sv
module rric_div
	import rric_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic             ovf,
	output logic [Q_W-1:0]   quot
);

	localparam int HI_W  = DVD_W - Q_W;
	localparam int CMP_W = (HI_W > DVS_W) ? HI_W : DVS_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;

	logic [HI_W-1:0]  hi;
	logic             hi_ovf;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   trial_sub;
	logic             ge;

	// Quotient would not fit when the upper dividend part reaches the divisor
	assign hi     = dividend[DVD_W-1:Q_W];
	assign hi_ovf = CMP_W'(hi) >= CMP_W'(divisor);

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial     = {rem_q, quo_q[Q_W-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (hi_ovf) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(Q_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= hi_ovf;
			rem_q <= DVS_W'(hi);
			quo_q <= dividend[Q_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quo_q;

endmodule

// File: rtl/rric_dp.sv
module rric_dp
	import rric_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [INDEX_W-1:0]    peak_index,
	input  logic [OFFSET_W-1:0]   window_offset,
	input  logic                  first_window,
	input  logic                  last_in_window,
	input  logic                  window_empty,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  window_error,
	output logic [OUT_RR_W-1:0]   last_rr_ms
);

	localparam logic [INTERVAL_WIDTH-1:0] RR_MAX = '1;

	// Configuration registers
	logic [SR_W-1:0] sample_rate_q;
	logic [MS_W-1:0] ms_scale_q;
	logic [RS_W-1:0] ratio_scale_q;
	logic [RB_W-1:0] ratio_low_q;
	logic [RB_W-1:0] ratio_high_q;

	// Item being worked on
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] diff_q;
	logic                      first_q;
	logic                      last_q;
	logic                      empty_q;

	// Window state
	logic [POSITION_WIDTH-1:0] prev_pos_q;
	logic [INTERVAL_WIDTH-1:0] prev_rr_q;
	logic                      have_q;
	logic                      err_q;
	logic                      rr_in_q;

	// Arithmetic
	logic [INTERVAL_WIDTH-1:0] rr_q;
	logic [DVD_W-1:0]          mul_q;
	logic [MA_W-1:0]           mul_a;
	logic [MB_W-1:0]           mul_b;
	logic [OFFSET_W:0]         pos_sum;
	logic [POSITION_WIDTH-1:0] pos_now;
	logic [DVS_W-1:0]          div_dvs;
	logic                      div_done;
	logic                      div_ovf;
	logic [Q_W-1:0]            div_quot;

	// Result register
	logic                      out_valid_q;
	logic                      out_err_q;
	logic [OUT_RR_W-1:0]       out_rr_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SAMPLE_RATE_RST;
			ms_scale_q    <= MS_SCALE_RST;
			ratio_scale_q <= RATIO_SCALE_RST;
			ratio_low_q   <= RATIO_LOW_RST;
			ratio_high_q  <= RATIO_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data[SR_W-1:0];
				REG_MS_SCALE:    ms_scale_q    <= cfg_data[MS_W-1:0];
				REG_RATIO_SCALE: ratio_scale_q <= cfg_data[RS_W-1:0];
				REG_RATIO_LOW:   ratio_low_q   <= cfg_data[RB_W-1:0];
				REG_RATIO_HIGH:  ratio_high_q  <= cfg_data[RB_W-1:0];
				default: ;
			endcase
		end
	end

	// Absolute position of the incoming peak, wrapped to the position width
	assign pos_sum = (OFFSET_W + 1)'(peak_index) + (OFFSET_W + 1)'(window_offset);
	assign pos_now = pos_sum[POSITION_WIDTH-1:0];

	// Capture the item and its distance from the previous peak
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= pos_now;
			diff_q  <= pos_now - prev_pos_q;
			first_q <= first_window;
			last_q  <= last_in_window;
			empty_q <= window_empty;
		end
	end

	// Shared multiplier: distance by ms_scale, or interval by ratio_scale
	assign mul_a = cmd.sel_ratio ? MA_W'(rr_q) : MA_W'(diff_q);
	assign mul_b = cmd.sel_ratio ? MB_W'(ratio_scale_q) : MB_W'(ms_scale_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mul_q <= {{MB_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};
		end
	end

	// Shared divider: by the sample rate, or by the previous interval
	assign div_dvs = cmd.sel_ratio ? DVS_W'(prev_rr_q) : DVS_W'(sample_rate_q);

	rric_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mul_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.ovf      (div_ovf),
		.quot     (div_quot)
	);

	// Take the interval, saturated to its maximum
	always_ff @(posedge clk) begin
		if (cmd.rr_take) begin
			if (div_ovf || (div_quot > Q_W'(RR_MAX))) begin
				rr_q <= RR_MAX;
			end else begin
				rr_q <= div_quot[INTERVAL_WIDTH-1:0];
			end
		end
	end

	// Window state: ratio checks, commits and closing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
			prev_rr_q  <= '0;
			have_q     <= 1'b0;
			err_q      <= 1'b0;
			rr_in_q    <= 1'b0;
		end else begin
			if (cmd.ratio_take) begin
				if (div_ovf || (div_quot < Q_W'(ratio_low_q)) ||
				    (div_quot > Q_W'(ratio_high_q))) begin
					err_q <= 1'b1;
				end
			end
			if (cmd.commit_skip) begin
				prev_rr_q  <= '0;
				rr_in_q    <= 1'b0;
				prev_pos_q <= pos_q;
				have_q     <= 1'b1;
			end
			if (cmd.commit_rr) begin
				prev_rr_q  <= rr_q;
				rr_in_q    <= 1'b1;
				prev_pos_q <= pos_q;
				have_q     <= 1'b1;
			end
			if (cmd.emit) begin
				have_q  <= 1'b0;
				err_q   <= 1'b0;
				rr_in_q <= 1'b0;
			end
		end
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_err_q <= empty_q | err_q;
			out_rr_q  <= OUT_RR_W'(prev_rr_q);
		end
	end

	// Status to the controller
	always_comb begin
		stat.empty    = empty_q;
		stat.skip     = !have_q && first_q;
		stat.last     = last_q;
		stat.check    = have_q ? rr_in_q : (prev_rr_q != '0);
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign window_error = out_err_q;
	assign last_rr_ms   = out_rr_q;

endmodule

// File: rtl/rric_ctrl.sv
module rric_ctrl
	import rric_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_RR_MUL,
		S_RR_GO,
		S_RR_WAIT,
		S_RT_MUL,
		S_RT_GO,
		S_RT_WAIT,
		S_COMMIT,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.empty) begin
					state_d = S_RESULT;
				end else if (stat.skip) begin
					cmd.commit_skip = 1'b1;
					state_d = stat.last ? S_RESULT : S_IDLE;
				end else begin
					state_d = S_RR_MUL;
				end
			end
			S_RR_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RR_GO;
			end
			S_RR_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_RR_WAIT;
			end
			S_RR_WAIT: begin
				if (stat.div_done) begin
					cmd.rr_take = 1'b1;
					state_d = stat.check ? S_RT_MUL : S_COMMIT;
				end
			end
			S_RT_MUL: begin
				cmd.mul       = 1'b1;
				cmd.sel_ratio = 1'b1;
				state_d = S_RT_GO;
			end
			S_RT_GO: begin
				cmd.div_start = 1'b1;
				cmd.sel_ratio = 1'b1;
				state_d = S_RT_WAIT;
			end
			S_RT_WAIT: begin
				if (stat.div_done) begin
					cmd.ratio_take = 1'b1;
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit_rr = 1'b1;
				state_d = stat.last ? S_RESULT : S_IDLE;
			end
			S_RESULT: begin
				// Hold the window result until the output register frees up
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// File: rtl/rr_interval_ratio_check.sv
// Channel   Handshake             Item fields
// in        in_valid / in_ready   peak_index, window_offset, first_window,
//                                 last_in_window, window_empty
// out       out_valid / out_ready window_error, last_rr_ms
// cfg       cfg_we (no stall)     cfg_index, cfg_data
//
// One item at a time. A peak with a ratio check makes two passes through the
// shared restoring divider, a peak without one makes one pass; an empty-window
// marker, and the first peak of a first window, make none.
// Reset (arst_n low) restores the register defaults and clears the window state.
// A result waits in the output register; the next item is taken meanwhile,
// and only a further window close stalls until that result is taken.
module rr_interval_ratio_check
	import rric_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [INDEX_W-1:0]    peak_index,
	input  logic [OFFSET_W-1:0]   window_offset,
	input  logic                  first_window,
	input  logic                  last_in_window,
	input  logic                  window_empty,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  window_error,
	output logic [OUT_RR_W-1:0]   last_rr_ms
);

	cmd_t  cmd;
	stat_t stat;

	rric_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rric_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.peak_index     (peak_index),
		.window_offset  (window_offset),
		.first_window   (first_window),
		.last_in_window (last_in_window),
		.window_empty   (window_empty),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_error   (window_error),
		.last_rr_ms     (last_rr_ms)
	);

	// A new result never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result emitted over a waiting result");

	// An emitted result is presented on the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("emitted result not presented");

	// Quotients are only taken when the divider has finished
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rr_take || cmd.ratio_take) |-> stat.div_done)
		else $error("quotient taken before divider finished");

	// No item is accepted while a division is under way
	a_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !in_ready)
		else $error("input ready during division");

endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rric_pkg::*;

	// One closed window as the block should report it
	typedef struct {
		logic        err;
		logic [15:0] rr;
	} window_verdict_t;

	// Tracks RR intervals and ratio checks; holds the verdicts still owed
	class rr_window_tracker;
		logic [SR_W-1:0] sample_rate;
		logic [MS_W-1:0] ms_scale;
		logic [RS_W-1:0] ratio_scale;
		logic [RB_W-1:0] ratio_low;
		logic [RB_W-1:0] ratio_high;
		logic [POSITION_WIDTH-1:0] last_pos;
		logic [INTERVAL_WIDTH-1:0] last_rr;
		bit peak_seen;
		bit err_seen;
		bit rr_seen;
		window_verdict_t verdicts[$];
		int mismatches;

		function new();
			sample_rate = SAMPLE_RATE_RST;
			ms_scale    = MS_SCALE_RST;
			ratio_scale = RATIO_SCALE_RST;
			ratio_low   = RATIO_LOW_RST;
			ratio_high  = RATIO_HIGH_RST;
			last_pos    = '0;
			last_rr     = '0;
			peak_seen   = 0;
			err_seen    = 0;
			rr_seen     = 0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SAMPLE_RATE: sample_rate = val[SR_W-1:0];
				REG_MS_SCALE:    ms_scale    = val[MS_W-1:0];
				REG_RATIO_SCALE: ratio_scale = val[RS_W-1:0];
				REG_RATIO_LOW:   ratio_low   = val;
				REG_RATIO_HIGH:  ratio_high  = val;
				default: ;
			endcase
		endfunction

		// Interval in ms since the previous peak, truncated then saturated
		function logic [INTERVAL_WIDTH-1:0] interval_to(logic [POSITION_WIDTH-1:0] pos);
			logic [POSITION_WIDTH-1:0] diff;
			longint unsigned prod;
			longint unsigned quot;
			diff = pos - last_pos;
			if (sample_rate == 0)
				return '1;
			prod = ms_scale;
			prod = prod * diff;
			quot = prod / sample_rate;
			if (quot > 64'hFFFF)
				return '1;
			return quot[INTERVAL_WIDTH-1:0];
		endfunction

		function bit ratio_out_of_bounds(logic [15:0] rr, logic [15:0] prev);
			longint unsigned ratio;
			if (prev == 0)
				return 1;
			ratio = ratio_scale;
			ratio = (ratio * rr) / prev;
			return (ratio < ratio_low) || (ratio > ratio_high);
		endfunction

		function void close_window();
			peak_seen = 0;
			err_seen  = 0;
			rr_seen   = 0;
		endfunction

		// Advance the window state for one accepted item
		function void take_item(logic [INDEX_W-1:0] idx, logic [OFFSET_W-1:0] off,
				logic fw, logic lw, logic emp);
			window_verdict_t v;
			logic [POSITION_WIDTH-1:0] pos;
			logic [INTERVAL_WIDTH-1:0] rr;
			bit probe;
			if (emp) begin
				v.err = 1'b1;
				v.rr  = last_rr;
				verdicts.push_back(v);
				close_window();
				return;
			end
			pos = off + {15'b0, idx};
			if (!peak_seen && fw) begin
				last_rr = '0;
				rr_seen = 0;
			end else begin
				rr = interval_to(pos);
				probe = peak_seen ? rr_seen : (last_rr != 0);
				if (probe && ratio_out_of_bounds(rr, last_rr))
					err_seen = 1;
				last_rr = rr;
				rr_seen = 1;
			end
			last_pos  = pos;
			peak_seen = 1;
			if (lw) begin
				v.err = err_seen;
				v.rr  = last_rr;
				verdicts.push_back(v);
				close_window();
			end
		endfunction

		// Compare one window result with the oldest verdict owed
		function void check_window(logic err, logic [OUT_RR_W-1:0] rr);
			window_verdict_t v;
			if (verdicts.size() == 0) begin
				$error("window result with none owed: window_error %0d last_rr_ms %0d", err, rr);
				mismatches++;
				return;
			end
			v = verdicts.pop_front();
			if (err !== v.err) begin
				$error("window_error: expected %0d, actual %0d", v.err, err);
				mismatches++;
			end
			if (rr !== v.rr) begin
				$error("last_rr_ms: expected %0d, actual %0d", v.rr, rr);
				mismatches++;
			end
		endfunction

		function int owed();
			return verdicts.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [INDEX_W-1:0]    peak_index;
	logic [OFFSET_W-1:0]   window_offset;
	logic                  first_window;
	logic                  last_in_window;
	logic                  window_empty;
	logic                  out_valid;
	logic                  out_ready;
	logic                  window_error;
	logic [OUT_RR_W-1:0]   last_rr_ms;

	rr_window_tracker tracker = new();
	bit steady;
	bit hold_off_req;

	rr_interval_ratio_check dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.peak_index     (peak_index),
		.window_offset  (window_offset),
		.first_window   (first_window),
		.last_in_window (last_in_window),
		.window_empty   (window_empty),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_error   (window_error),
		.last_rr_ms     (last_rr_ms)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random back-pressure, with one long hold-off on request
	initial begin
		int held;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready = 1'b0;
				for (held = 0; held < 800; held++)
					@(negedge clk);
			end
			out_ready = steady || ($urandom_range(99) >= 36);
		end
	end

	// Check every window result taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_window(window_error, last_rr_ms);
	end

	// Offer one item, with random idle cycles first; returns at a falling edge
	task automatic send_item(input logic [INDEX_W-1:0] idx, input logic [OFFSET_W-1:0] off,
			input logic fw, input logic lw, input logic emp);
		while (!steady && $urandom_range(99) < 36) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid       = 1'b1;
		peak_index     = idx;
		window_offset  = off;
		first_window   = fw;
		last_in_window = lw;
		window_empty   = emp;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_item(idx, off, fw, lw, emp);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		tracker.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [SR_W-1:0] rate, input logic [MS_W-1:0] ms,
			input logic [RS_W-1:0] rs, input logic [RB_W-1:0] lo, input logic [RB_W-1:0] hi);
		put_reg(REG_SAMPLE_RATE, {3'b0, rate});
		put_reg(REG_MS_SCALE, {6'b0, ms});
		put_reg(REG_RATIO_SCALE, {5'b0, rs});
		put_reg(REG_RATIO_LOW, lo);
		put_reg(REG_RATIO_HIGH, hi);
		cfg_we = 1'b0;
	endtask

	// Wait for every owed window, then let a peak still in flight finish
	task automatic settle();
		in_valid = 1'b0;
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic random_regs();
		int rs;
		rs = $urandom_range(1, 1024);
		program_regs($urandom_range(1, 4096), $urandom_range(1, 1000), rs,
			rs * $urandom_range(30, 90) / 100, rs * $urandom_range(110, 300) / 100);
	endtask

	// Mostly plausible heartbeat windows, some junk and broken windows
	task automatic random_phase(input int quota);
		int sent;
		int kind;
		int npk;
		int k;
		int beat;
		int rel;
		int back;
		longint unsigned span;
		logic [POSITION_WIDTH-1:0] cursor;
		logic [OFFSET_W-1:0] woff;
		logic [31:0] r;
		bit fresh;
		sent = 0;
		fresh = 1;
		if (tracker.ms_scale == 0)
			span = 12000;
		else
			span = (40000 * longint'(tracker.sample_rate)) / tracker.ms_scale;
		if (span < 8)
			span = 8;
		if (span > 12000)
			span = 12000;
		beat = $urandom_range(span / 4 + 1, span);
		r = $urandom;
		cursor = r[30:0];
		while (sent < quota) begin
			kind = $urandom_range(99);
			if (kind < 6) begin
				// empty marker with junk in the ignored fields
				r = $urandom;
				send_item($urandom, r[30:0], r[31], $urandom_range(1), 1'b1);
				sent++;
			end else if (kind < 16) begin
				// stray peak anywhere, any flags
				r = $urandom;
				send_item($urandom, r[30:0], $urandom_range(1), $urandom_range(1), 1'b0);
				sent++;
			end else begin
				npk = $urandom_range(1, 4);
				back = $urandom_range(0, 1000);
				woff = cursor - back;
				rel = back;
				for (k = 0; k < npk; k++) begin
					// drop the closing mark now and then, merging into the next window
					send_item(rel, woff, (k == 0) ? fresh : $urandom_range(1),
						(k == npk - 1) && (kind >= 22), 1'b0);
					sent++;
					beat = beat;
					rel = beat + int'($urandom_range(0, beat / 2)) - beat / 4;
					cursor = cursor + rel;
					rel = cursor - woff;
				end
				fresh = ($urandom_range(19) == 0);
			end
		end
	endtask

	initial begin
		int waited;
		int ph;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_SAMPLE_RATE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		peak_index     = '0;
		window_offset  = '0;
		first_window   = 1'b0;
		last_in_window = 1'b0;
		window_empty   = 1'b0;
		steady         = 0;
		hold_off_req   = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed windows at the reset settings (4 ms per sample)
		send_item(16'hFFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_item(100, 0, 1'b0, 1'b0, 1'b0);
		send_item(200, 0, 1'b1, 1'b1, 1'b0);
		send_item(50, 300, 1'b0, 1'b1, 1'b0);
		send_item(0, 1350, 1'b0, 1'b1, 1'b0);
		send_item(0, 5000, 1'b1, 1'b0, 1'b0);
		send_item(16'hFFFF, 5000, 1'b0, 1'b0, 1'b0);
		send_item(16'hFFFF, 31'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
		send_item(0, 0, 1'b1, 1'b1, 1'b0);
		send_item(10, 0, 1'b0, 1'b0, 1'b0);
		send_item(10, 0, 1'b0, 1'b0, 1'b0);
		send_item(20, 0, 1'b1, 1'b1, 1'b0);
		send_item(100, 0, 1'b0, 1'b0, 1'b0);
		send_item(0, 0, 1'b0, 1'b0, 1'b1);
		send_item(200, 0, 1'b0, 1'b1, 1'b0);
		send_item(150, 0, 1'b0, 1'b1, 1'b0);
		settle();

		// Stall the output for a long stretch while items keep coming
		random_regs();
		hold_off_req = 1'b1;
		random_phase(130);
		settle();

		// Widest scales, widest bounds, no idling on either side
		program_regs(13'd1, 10'd1023, 11'd2047, 16'd0, 16'hFFFF);
		steady = 1;
		random_phase(130);
		steady = 0;
		settle();

		// Zero sample rate, inverted bounds
		program_regs(13'd0, 10'd1, 11'd1, 16'hFFFF, 16'd0);
		random_phase(90);
		settle();

		program_regs(13'h1FFF, 10'd1000, 11'd1024, 16'd512, 16'd2048);
		random_phase(130);
		settle();

		for (ph = 0; ph < 4; ph++) begin
			random_regs();
			random_phase(140);
			settle();
		end

		waited = 0;
		while (tracker.owed() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(negedge clk);
		if (tracker.owed() != 0) begin
			$error("%0d window results never arrived", tracker.owed());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
